// ===== sv/shp_pkg.sv =====
// Shared types and constants for the shadow poison checker.
package shp_pkg;

   // Payload widths of the request and response transactions.
   localparam int ADDR_W = 15;
   localparam int LEN_W  = 16;
   localparam int CODE_W = 8;
   localparam int OP_W   = 2;

   // Granule geometry: eight bytes per shadow byte.
   localparam int GRAN_SHIFT = 3;
   localparam int GRAN_W     = 13;
   localparam int END_W      = 17;
   localparam int CEIL_W     = 14;

   // Operation codes of a request.
   typedef enum logic [OP_W-1:0] {
      OP_POISON   = 2'd0,
      OP_UNPOISON = 2'd1,
      OP_CHECK    = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic issue;
   } shp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic skip;
      logic issue_last;
   } shp_status_type;

endpackage

// ===== sv/shp_if.sv =====
// Request and response channel interfaces of the shadow poison checker.
interface shp_req_if;
   import shp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [ADDR_W-1:0]        address;
   logic [LEN_W-1:0]         length;
   logic signed [CODE_W-1:0] poison_code;

   modport source (output valid, output operation, output address, output length,
                   output poison_code, input ready);
   modport sink   (input valid, input operation, input address, input length,
                   input poison_code, output ready);
endinterface

interface shp_rsp_if;
   logic valid;
   logic ready;
   logic range_valid;
   logic range_error;

   modport source (output valid, output range_valid, output range_error, input ready);
   modport sink   (input valid, input range_valid, input range_error, output ready);
endinterface

// ===== sv/shp_ctrl.sv =====
// Controller state machine: clearing pass, granule walk and response handshake.
module shp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  shp_pkg::shp_status_type status,
   output shp_pkg::shp_cmd_type    cmd
);
   import shp_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // Commands follow directly from the state and the request handshake.
   assign cmd.clear = (state_ff == ST_CLEAR);
   assign cmd.load  = req_valid && req_ready_ff;
   assign cmd.issue = (state_ff == ST_WALK);

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // State register with the registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  if (status.skip) begin
                     state_ff     <= ST_RESP;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               if (status.issue_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

endmodule

// ===== sv/shp_dpath.sv =====
// Datapath: request registers, shadow memory and the per-granule update and check logic.
module shp_dpath #(
   parameter int SHADOW_ENTRIES = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  shp_pkg::shp_cmd_type             cmd,
   output shp_pkg::shp_status_type          status,
   input  logic [shp_pkg::OP_W-1:0]         operation,
   input  logic [shp_pkg::ADDR_W-1:0]       address,
   input  logic [shp_pkg::LEN_W-1:0]        length,
   input  logic signed [shp_pkg::CODE_W-1:0] poison_code,
   output logic                             range_valid,
   output logic                             range_error
);
   import shp_pkg::*;

   localparam int          IW        = $clog2(SHADOW_ENTRIES);
   localparam logic [31:0] ENTRIES_W = 32'(SHADOW_ENTRIES);

   // Shadow memory, one byte per granule.
   logic [CODE_W-1:0] shadow_mem [SHADOW_ENTRIES];

   // Transaction registers.
   op_type             op_ff;
   logic [2:0]         k_ff;
   logic [2:0]         r_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [END_W-1:0]   klen_ff;
   logic [GRAN_W-1:0]  first_ff;
   logic [GRAN_W-1:0]  last_ff;
   logic               err_ff;
   logic               ok_ff;
   logic               ok_in;

   // Walk pipeline registers.
   logic [GRAN_W-1:0]  g_ff;
   logic [GRAN_W-1:0]  s2_g_ff;
   logic               s2_valid_ff;
   logic [CODE_W-1:0]  rd_data_ff;
   logic [IW-1:0]      clr_ff;

   // Incoming range geometry.
   logic [END_W-1:0]   end_in;
   logic [END_W-1:0]   endm1_in;
   logic [END_W-1:0]   endp7_in;
   logic [CEIL_W-1:0]  ceil_in;
   logic               nonempty_in;
   logic               err_in;

   assign end_in      = END_W'(address) + END_W'(length);
   assign endm1_in    = end_in - END_W'(1);
   assign endp7_in    = end_in + END_W'(7);
   assign ceil_in     = endp7_in[END_W-1:GRAN_SHIFT];
   assign nonempty_in = (length != '0);
   assign err_in      = nonempty_in && (op_type'(operation) != OP_NOP)
                        && ({18'd0, ceil_in} > ENTRIES_W);

   // Nothing to walk for an empty range, an out-of-store range or a no-op.
   assign status.skip       = !nonempty_in || err_in || (op_type'(operation) == OP_NOP);
   assign status.issue_last = (g_ff == last_ff);
   assign status.clear_last = (clr_ff == IW'(SHADOW_ENTRIES - 1));

   // Capture the transaction and step the granule address.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(operation);
         k_ff     <= address[2:0];
         r_ff     <= end_in[2:0];
         code_ff  <= poison_code;
         klen_ff  <= END_W'(address[2:0]) + END_W'(length);
         first_ff <= address[ADDR_W-1:GRAN_SHIFT];
         last_ff  <= endm1_in[GRAN_SHIFT+GRAN_W-1:GRAN_SHIFT];
         g_ff     <= address[ADDR_W-1:GRAN_SHIFT];
         err_ff   <= err_in;
      end else if (cmd.issue) begin
         g_ff <= g_ff + GRAN_W'(1);
      end
      s2_g_ff <= g_ff;
   end

   // Control registers of the walk and the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         clr_ff      <= '0;
         ok_ff       <= 1'b1;
      end else begin
         s2_valid_ff <= cmd.issue;
         if (cmd.clear) begin
            clr_ff <= clr_ff + IW'(1);
         end
         ok_ff <= ok_in;
      end
   end

   // Evaluate one granule as its shadow byte returns from memory.
   logic signed [CODE_W-1:0] s_val;
   logic signed [CODE_W-1:0] k_val;
   logic signed [CODE_W-1:0] r_val;
   logic                     is_head;
   logic                     is_tail;
   logic                     wr_en;
   logic [CODE_W-1:0]        wr_data;
   logic                     gran_ok;

   assign s_val   = $signed(rd_data_ff);
   assign k_val   = $signed({5'd0, k_ff});
   assign r_val   = $signed({5'd0, r_ff});
   assign is_head = (k_ff != 3'd0) && (s2_g_ff == first_ff);
   assign is_tail = (r_ff != 3'd0) && (s2_g_ff == last_ff) && !is_head;

   always_comb begin
      wr_en   = 1'b0;
      wr_data = '0;
      gran_ok = 1'b1;
      if (s2_valid_ff) begin
         unique case (op_ff)
            OP_POISON: begin
               if (is_head) begin
                  // A head granule only shrinks when the whole range lies inside it.
                  wr_en   = (first_ff == last_ff) && ((s_val == 0) || (s_val > k_val));
                  wr_data = k_val;
               end else if (is_tail) begin
                  wr_en   = (s_val < 0) || ((s_val > 0) && (s_val <= r_val));
                  wr_data = code_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = code_ff;
               end
            end
            OP_UNPOISON: begin
               if (is_tail) begin
                  wr_en   = (s_val != 0) && (s_val < r_val);
                  wr_data = r_val;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = '0;
               end
            end
            OP_CHECK: begin
               if (is_head) begin
                  gran_ok = (s_val == 0)
                            || ((s_val > 0) && ({10'd0, s_val[6:0]} >= klen_ff));
               end else if (is_tail) begin
                  gran_ok = (s_val == 0) || (s_val >= r_val);
               end else begin
                  gran_ok = (s_val == 0);
               end
            end
            OP_NOP: begin
               gran_ok = 1'b1;
            end
            default: begin
               gran_ok = 1'b1;
            end
         endcase
      end
   end

   // The check verdict restarts with each transaction and accumulates per granule.
   always_comb begin
      if (cmd.load) begin
         ok_in = 1'b1;
      end else begin
         ok_in = ok_ff && gran_ok;
      end
   end

   // Memory port: the clearing pass writes zero ahead of any granule update.
   logic [IW-1:0]     mem_wa;
   logic [CODE_W-1:0] mem_wd;
   logic              mem_we;

   assign mem_we = cmd.clear || wr_en;
   assign mem_wa = cmd.clear ? clr_ff : IW'(s2_g_ff);
   assign mem_wd = cmd.clear ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= shadow_mem[IW'(g_ff)];
   end

   // Response fields come straight from the transaction registers.
   assign range_error = err_ff;
   assign range_valid = (op_ff == OP_CHECK) && !err_ff && ok_ff;

endmodule

// ===== sv/shadow_poison_checker_unit.sv =====
// Top level: after reset a clearing pass writes zero to all SHADOW_ENTRIES entries, one a cycle.
// No request is taken during the clearing pass.
// A walking request steps through its granules in ST_WALK, then passes ST_DRAIN before its response shows.
// Empty, out-of-store and no-op requests respond in the cycle after acceptance.
// A new request is taken only once the response has been taken; the walk reads one granule a cycle.
// Reset is synchronous and active high; it restarts the clearing pass.
module shadow_poison_checker_unit #(
   parameter int SHADOW_ENTRIES = 4096
) (
   input  logic      clock,
   input  logic      reset,
   shp_req_if.sink   req_bus,
   shp_rsp_if.source rsp_bus
);
   import shp_pkg::*;

   shp_cmd_type    cmd;
   shp_status_type status;
   logic           req_ready;
   logic           rsp_valid;
   logic           range_valid;
   logic           range_error;

   // Sequencing of the clearing pass, the walk and the handshakes.
   shp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Shadow memory and granule logic.
   shp_dpath #(
      .SHADOW_ENTRIES (SHADOW_ENTRIES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .operation   (req_bus.operation),
      .address     (req_bus.address),
      .length      (req_bus.length),
      .poison_code (req_bus.poison_code),
      .range_valid (range_valid),
      .range_error (range_error)
   );

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.range_valid = range_valid;
   assign rsp_bus.range_error = range_error;

   // A range that ran past the store is never also reported as valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.range_error && rsp_bus.range_valid))
      else $error("range reported both valid and in error");

   // The walk never runs while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !rsp_bus.valid)
      else $error("granule walk while a response waits");

   // No transaction is accepted during the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_bus.ready)
      else $error("request accepted during clearing pass");

   // A response is followed by readiness once it has been taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready |=> req_bus.ready && !rsp_bus.valid)
      else $error("block did not return to ready after a response");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the shadow poison checker: random traffic checked against a shadow image.
module tb_top;
   import shp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHADOW_ENTRIES = 4096;
   localparam int STORE_BYTES    = SHADOW_ENTRIES * 8;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int DRAIN_CYCLES   = 16;

   // One request transaction as the sender offers it.
   typedef struct {
      op_type                   op;
      logic [ADDR_W-1:0]        address;
      logic [LEN_W-1:0]         length;
      logic signed [CODE_W-1:0] code;
   } range_req_type;

   // One predicted response transaction.
   typedef struct {
      logic range_valid;
      logic range_error;
   } range_rsp_type;

   logic clock;
   logic reset;

   shp_req_if req_bus ();
   shp_rsp_if rsp_bus ();

   shadow_poison_checker_unit #(
      .SHADOW_ENTRIES(SHADOW_ENTRIES)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Shadow image kept by the predictor, one signed byte per granule.
   logic signed [7:0] shadow_image [SHADOW_ENTRIES];

   range_req_type pending_items [$];
   range_rsp_type expected_rsp [$];

   range_req_type offer_item;
   logic          offer_busy;
   int            burst_left;
   int            gap_left;
   int            items_total;
   int            accepted_count;
   int            responses_seen;
   int            fail_count;
   int            cycle_count;

   int            rx_mode;
   int            rx_mode_left;
   int            hold_left;
   logic          hold_done;

   // Granules past the store read as zero and ignore writes.
   function automatic int shadow_rd(input int g);
      if (g >= SHADOW_ENTRIES) return 0;
      return int'(shadow_image[g]);
   endfunction

   function automatic void shadow_wr(input int g, input int v);
      if (g < SHADOW_ENTRIES) shadow_image[g] = 8'(v);
   endfunction

   // Poison: a partial head granule only shrinks when the whole range fits inside it.
   function automatic void poison_range(input int addr, input int len, input int code);
      int g, k, n, room, whole, r, s;
      g = addr >> 3;
      k = addr & 7;
      n = len;
      if (k != 0) begin
         room = 8 - k;
         s = shadow_rd(g);
         if (n != 0 && (s == 0 || s > k) && room >= n) shadow_wr(g, k);
         g++;
         n -= (room < n) ? room : n;
      end
      whole = n >> 3;
      for (int i = 0; i < whole; i++) shadow_wr(g + i, code);
      r = n & 7;
      if (r != 0) begin
         g += whole;
         s = shadow_rd(g);
         if (s < 0 || (s > 0 && s <= r)) shadow_wr(g, code);
      end
   endfunction

   // Unpoison: the head granule opens fully, a short tail grows to the remaining bytes.
   function automatic void unpoison_range(input int addr, input int len);
      int g, k, n, room, whole, r, s;
      g = addr >> 3;
      k = addr & 7;
      n = len;
      if (k != 0) begin
         room = 8 - k;
         if (n != 0) shadow_wr(g, 0);
         g++;
         n -= (room < n) ? room : n;
      end
      whole = n >> 3;
      for (int i = 0; i < whole; i++) shadow_wr(g + i, 0);
      r = n & 7;
      if (r != 0) begin
         g += whole;
         s = shadow_rd(g);
         if (s != 0 && s < r) shadow_wr(g, r);
      end
   endfunction

   // Check: the head comparison is signed against offset plus the full length.
   function automatic logic range_is_clean(input int addr, input int len);
      int g, k, n, room, whole, r, s;
      g = addr >> 3;
      k = addr & 7;
      n = len;
      if (n == 0) return 1'b1;
      if (k != 0) begin
         room = 8 - k;
         s = shadow_rd(g);
         if (!(s == 0 || (s > 0 && s >= k + n))) return 1'b0;
         g++;
         n -= (room < n) ? room : n;
      end
      whole = n >> 3;
      for (int i = 0; i < whole; i++)
         if (shadow_rd(g + i) != 0) return 1'b0;
      r = n & 7;
      if (r != 0) begin
         s = shadow_rd(g + whole);
         if (!(s == 0 || s >= r)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Applies one accepted request to the shadow image and returns its response.
   function automatic range_rsp_type apply_range_request(input range_req_type t);
      range_rsp_type res;
      int addr, len;
      addr = t.address;
      len  = t.length;
      res.range_valid = 1'b0;
      res.range_error = 1'b0;
      if (t.op != OP_NOP) begin
         if (len != 0 && ((addr + len + 7) >> 3) > SHADOW_ENTRIES) begin
            res.range_error = 1'b1;
         end else begin
            case (t.op)
               OP_POISON:   poison_range(addr, len, int'(t.code));
               OP_UNPOISON: unpoison_range(addr, len);
               OP_CHECK:    res.range_valid = range_is_clean(addr, len);
               default:     ;
            endcase
         end
      end
      return res;
   endfunction

   function automatic void add_item(input op_type op, input int addr, input int len,
                                    input int code);
      range_req_type t;
      t.op      = op;
      t.address = ADDR_W'(addr);
      t.length  = LEN_W'(len);
      t.code    = CODE_W'(code);
      pending_items.push_back(t);
   endfunction

   // Poison codes stay negative; other operations carry any code value.
   function automatic int neg_code();
      return int'($urandom_range(0, 127)) - 128;
   endfunction

   function automatic int any_code();
      return int'($urandom_range(0, 255)) - 128;
   endfunction

   // One unstructured request, with addresses mostly in a dense low window.
   function automatic void add_noise_item();
      int pick, addr, len, op_pick;
      op_type op;
      pick = $urandom_range(0, 99);
      if (pick < 75)      addr = $urandom_range(0, 511);
      else if (pick < 85) addr = STORE_BYTES - 256 + $urandom_range(0, 255);
      else                addr = $urandom_range(0, STORE_BYTES - 1);
      pick = $urandom_range(0, 199);
      if (pick < 10)       len = 0;
      else if (pick < 150) len = $urandom_range(1, 24);
      else if (pick < 178) len = $urandom_range(25, 300);
      else if (pick < 186) len = $urandom_range(301, 4000);
      else if (pick < 188) begin
         len = STORE_BYTES;
         if ($urandom_range(0, 1) == 0) addr = 0;
      end else begin
         len = $urandom_range(STORE_BYTES + 1, 65535);
      end
      op_pick = $urandom_range(0, 99);
      if (op_pick < 30)      op = OP_POISON;
      else if (op_pick < 55) op = OP_UNPOISON;
      else if (op_pick < 95) op = OP_CHECK;
      else                   op = OP_NOP;
      add_item(op, addr, len, (op == OP_POISON) ? neg_code() : any_code());
   endfunction

   // An allocation-like sequence: open a region, fence it, probe it, maybe free it.
   function automatic void add_alloc_sequence();
      int base, size;
      base = $urandom_range(0, 60) * 8;
      if ($urandom_range(0, 3) == 0) base += $urandom_range(1, 7);
      size = $urandom_range(1, 64);
      add_item(OP_UNPOISON, base, size, any_code());
      add_item(OP_POISON, base + size, $urandom_range(1, 32), neg_code());
      repeat ($urandom_range(1, 4))
         add_item(OP_CHECK, base + $urandom_range(0, size + 8), $urandom_range(0, size + 8),
                  any_code());
      if ($urandom_range(0, 1) == 0) begin
         add_item(OP_POISON, base, size, neg_code());
         add_item(OP_CHECK, base + $urandom_range(0, size), $urandom_range(1, 16), any_code());
      end
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Known values on every input from time zero.
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_NOP;
      req_bus.address     = '0;
      req_bus.length      = '0;
      req_bus.poison_code = '0;
      rsp_bus.ready       = 1'b0;
      offer_busy          = 1'b0;
      burst_left          = 1;
      gap_left            = 0;
      accepted_count      = 0;
      responses_seen      = 0;
      fail_count          = 0;
      cycle_count         = 0;
      rx_mode             = 0;
      rx_mode_left        = 0;
      hold_left           = 0;
      hold_done           = 1'b0;
      foreach (shadow_image[i]) shadow_image[i] = '0;
   end

   // Stimulus, reset and end of run.
   initial begin
      reset = 1'b1;

      // Directed part: empty ranges, the unused code, head and tail rules, store edges.
      add_item(OP_CHECK, 0, 0, 0);
      add_item(OP_POISON, 8, 0, -1);
      add_item(OP_NOP, STORE_BYTES - 1, 65535, -1);
      add_item(OP_CHECK, 0, STORE_BYTES, 127);
      add_item(OP_POISON, 16, 16, -128);
      add_item(OP_CHECK, 20, 1, 0);
      add_item(OP_POISON, 3, 2, -1);
      add_item(OP_CHECK, 0, 3, 0);
      add_item(OP_CHECK, 1, 3, 0);
      add_item(OP_CHECK, 1, 2, 0);
      add_item(OP_UNPOISON, 16, 13, 0);
      add_item(OP_CHECK, 16, 13, 0);
      add_item(OP_CHECK, 16, 14, 0);
      add_item(OP_POISON, 26, 14, -2);
      add_item(OP_POISON, 40, 5, -128);
      add_item(OP_UNPOISON, 40, 5, 0);
      add_item(OP_POISON, STORE_BYTES - 8, 8, -1);
      add_item(OP_CHECK, STORE_BYTES - 1, 1, 0);
      add_item(OP_CHECK, STORE_BYTES - 8, 9, 0);
      add_item(OP_POISON, STORE_BYTES - 1, 2, -1);
      add_item(OP_UNPOISON, STORE_BYTES - 1, 1, 0);
      add_item(OP_CHECK, 0, 65535, 0);
      add_item(OP_CHECK, 0, STORE_BYTES, 0);
      add_item(OP_UNPOISON, 0, STORE_BYTES, 0);
      add_item(OP_CHECK, 0, STORE_BYTES, 0);

      // Random part: mostly allocation-like sequences, the rest unstructured requests.
      items_total = pending_items.size() + RANDOM_ITEMS;
      while (pending_items.size() < items_total) begin
         if ($urandom_range(0, 99) < 60) add_alloc_sequence();
         else                            add_noise_item();
      end
      items_total = pending_items.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == items_total);
      wait (expected_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d responses still outstanding at end of run", expected_rsp.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASS shadow_poison_checker_unit");
      end else begin
         $display("FAIL shadow_poison_checker_unit");
      end
      $finish;
   end

   // Request driver: bursts of transactions separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_rsp.push_back(apply_range_request(offer_item));
            accepted_count++;
            offer_busy = 1'b0;
         end
         if (!offer_busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               offer_item = pending_items.pop_front();
               offer_busy = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  // A quarter of the bursts are long stretches with no idling.
                  if ($urandom_range(0, 3) == 0) begin
                     burst_left = $urandom_range(20, 80);
                     gap_left   = 0;
                  end else begin
                     burst_left = $urandom_range(1, 12);
                     gap_left   = $urandom_range(1, 8);
                  end
               end
            end
         end
         req_bus.valid       <= offer_busy;
         req_bus.operation   <= offer_item.op;
         req_bus.address     <= offer_item.address;
         req_bus.length      <= offer_item.length;
         req_bus.poison_code <= offer_item.code;
      end
   end

   // Response receiver: changing stall patterns, plus one long hold-off.
   always @(posedge clock) begin
      logic take;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!hold_done && responses_seen >= 200) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(10, 150);
         end else begin
            rx_mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            case (rx_mode)
               0:       take = 1'b1;
               1:       take = 1'($urandom_range(0, 1));
               default: take = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_bus.ready <= take;
      end
   end

   // Response monitor: compare each transaction with the oldest prediction.
   always @(posedge clock) begin
      range_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_seen++;
         if (expected_rsp.size() == 0) begin
            $error("response transaction with no request outstanding");
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_bus.range_valid !== want.range_valid) begin
               $error("range_valid: expected %0b, actual %0b", want.range_valid,
                      rsp_bus.range_valid);
               fail_count++;
            end
            if (rsp_bus.range_error !== want.range_error) begin
               $error("range_error: expected %0b, actual %0b", want.range_error,
                      rsp_bus.range_error);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles", CYCLE_LIMIT);
         $display("FAIL shadow_poison_checker_unit");
         $finish;
      end
   end

endmodule
